// ----- design/iapp_pkg.sv -----
// shared constants and types for the imu angle packet parser
// no dependencies

package iapp_pkg;

   localparam int PacketLength = 11;
   localparam int PosWidth     = 4;
   localparam int PosNextWidth = PosWidth + 1;
   localparam int AngleBase    = 4;
   localparam int AngleBytes   = 6;
   localparam int AngleCount   = 3;

   localparam logic [7:0] HeaderByte = 8'h55;
   localparam logic [7:0] TypeAngle  = 8'h01;

   localparam logic signed [8:0] AngleScale = 9'sd180;

   typedef logic signed [15:0] angle_type;

   typedef struct packed {
      logic      busy;
      logic      hit;
      angle_type raw_roll;
      angle_type raw_pitch;
      angle_type raw_yaw;
   } frame_event_type;

endpackage

// ----- design/iapp_framer.sv -----
// byte framer: request register, packet position and byte stores
// depends on iapp_pkg

module iapp_framer
   import iapp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [7:0]      req_rx_byte,
   input  logic            advance,
   output frame_event_type frame_event
);

   logic                 byte_valid_ff;
   logic [7:0]           byte_ff;
   logic [PosWidth-1:0]  pos_ff;
   logic [PosWidth-1:0]  pos_in;
   logic [7:0]           header_ff [2];
   logic [7:0]           type_ff;
   logic [7:0]           angle_ff [AngleBytes];

   logic [7:0]           hdr0;
   logic [7:0]           hdr1;
   logic [7:0]           ptype;
   logic [7:0]           angle_view [AngleBytes];
   logic [PosNextWidth-1:0] pos_next;
   logic                 header_bad;
   logic                 last_byte;
   logic                 load;

   // a new request may enter whenever the held one leaves
   assign load = !byte_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (load) begin
         byte_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         byte_ff <= req_rx_byte;
      end
   end

   // byte stores as they look after the held byte is written
   always_comb begin
      hdr0  = (pos_ff == PosWidth'(0)) ? byte_ff : header_ff[0];
      hdr1  = (pos_ff == PosWidth'(1)) ? byte_ff : header_ff[1];
      ptype = (pos_ff == PosWidth'(2)) ? byte_ff : type_ff;
      for (int i = 0; i < AngleBytes; i++) begin
         angle_view[i] = (pos_ff == PosWidth'(AngleBase + i)) ? byte_ff : angle_ff[i];
      end
   end

   always_comb begin
      pos_next   = {1'b0, pos_ff} + PosNextWidth'(1);
      header_bad = (pos_next >= PosNextWidth'(2)) &&
                   !(hdr0 == HeaderByte && hdr1 == HeaderByte);
      last_byte  = pos_next >= PosNextWidth'(PacketLength);
      if (header_bad || last_byte) begin
         pos_in = '0;
      end else begin
         pos_in = pos_next[PosWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         header_ff[0] <= hdr0;
         header_ff[1] <= hdr1;
         type_ff      <= ptype;
         for (int i = 0; i < AngleBytes; i++) begin
            angle_ff[i] <= angle_view[i];
         end
      end
   end

   always_comb begin
      frame_event.busy      = byte_valid_ff;
      frame_event.hit       = byte_valid_ff && !header_bad && last_byte && ptype == TypeAngle;
      frame_event.raw_roll  = {angle_view[1], angle_view[0]};
      frame_event.raw_pitch = {angle_view[3], angle_view[2]};
      frame_event.raw_yaw   = {angle_view[5], angle_view[4]};
   end

endmodule

// ----- design/iapp_scale.sv -----
// scales a raw 16-bit angle to degrees with 7 fraction bits
// depends on iapp_pkg

module iapp_scale
   import iapp_pkg::*;
(
   input  angle_type raw,
   output angle_type degrees
);

   logic signed [24:0] prod;

   // raw * 180 then floor shift by 8, the low bits drop
   always_comb begin
      prod    = 25'(raw) * 25'(AngleScale);
      degrees = prod[23:8];
   end

endmodule

// ----- design/imu_angle_packet_parser_unit.sv -----
// Frames 11-byte serial packets (header 0x55 0x55, type 0x01) and reports
// roll, pitch and yaw in degrees with 7 fraction bits.
//
// Request channel: req_valid / req_stall / req_rx_byte, one byte per request.
// Result channel: rsp_valid / rsp_stall / rsp_*_angle, one result for each
// completed angle packet; other bytes and packet types give no result.
// A request is taken at an edge with valid high and stall low.
//
// A byte is held in the request register; the result of the last byte of
// a packet is registered as that byte leaves it and then shows on rsp_valid.
// Throughput: one byte per cycle. The held byte and the result register
// are separate, so bytes keep flowing while a result waits; only a
// packet-ending byte waits behind a stalled result, which then stalls
// the request side.
// Reset (synchronous, active high) empties both registers and returns the
// packet position to zero; the byte stores need no clearing.
// depends on iapp_pkg, iapp_framer, iapp_scale

module imu_angle_packet_parser_unit
   import iapp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);

   frame_event_type frame_event;
   logic            advance;
   logic            out_free;
   logic            rsp_valid_ff;
   angle_type       roll_ff;
   angle_type       pitch_ff;
   angle_type       yaw_ff;
   angle_type       roll_in;
   angle_type       pitch_in;
   angle_type       yaw_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = frame_event.busy && (!frame_event.hit || out_free);
   assign req_stall = frame_event.busy && !advance;

   iapp_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .frame_event (frame_event)
   );

   iapp_scale u_scale_roll (
      .raw     (frame_event.raw_roll),
      .degrees (roll_in)
   );

   iapp_scale u_scale_pitch (
      .raw     (frame_event.raw_pitch),
      .degrees (pitch_in)
   );

   iapp_scale u_scale_yaw (
      .raw     (frame_event.raw_yaw),
      .degrees (yaw_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= frame_event.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && frame_event.hit) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

endmodule

// ----- bench/imu_angle_packet_parser_unit_test.sv -----
// testbench for imu_angle_packet_parser_unit: drives framed and broken byte streams
// and checks roll, pitch and yaw against an in-bench packet framer model
// depends on iapp_pkg and the imu_angle_packet_parser_unit design

module imu_angle_packet_parser_unit_test
   import iapp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBytes = 2000;

   typedef struct {
      angle_type roll;
      angle_type pitch;
      angle_type yaw;
   } angle_triplet_type;

   typedef enum logic [1:0] {
      StallFree,
      StallLight,
      StallHeavy,
      StallPeriodic
   } stall_mode_type;

   // tracks packet framing and holds the angle triplets still owed by the block
   class angle_frame_tracker;
      int                pos;
      logic [7:0]        header [2];
      logic [7:0]        kind_byte;
      logic [7:0]        angle_store [AngleBytes];
      angle_triplet_type pending [$];
      int                mismatches;
      int                checked;

      function new();
         pos = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      // raw little-endian value times 180, floor shift by 8
      function angle_type to_degrees(logic [7:0] lo, logic [7:0] hi);
         logic signed [15:0] raw;
         logic signed [24:0] prod;
         logic signed [24:0] shifted;
         raw = {hi, lo};
         prod = raw * 25'sd180;
         shifted = prod >>> 8;
         return shifted[15:0];
      endfunction

      function void note_byte(logic [7:0] b);
         int                next;
         angle_triplet_type trip;
         if (pos < 2) begin
            header[pos] = b;
         end else if (pos == 2) begin
            kind_byte = b;
         end else if (pos >= AngleBase && pos < AngleBase + AngleBytes) begin
            angle_store[pos - AngleBase] = b;
         end
         next = pos + 1;
         // header is judged only once both bytes are held
         if (next >= 2 && !(header[0] == HeaderByte && header[1] == HeaderByte)) begin
            pos = 0;
            return;
         end
         if (next >= PacketLength) begin
            pos = 0;
            if (kind_byte == TypeAngle) begin
               trip.roll  = to_degrees(angle_store[0], angle_store[1]);
               trip.pitch = to_degrees(angle_store[2], angle_store[3]);
               trip.yaw   = to_degrees(angle_store[4], angle_store[5]);
               pending.push_back(trip);
            end
            return;
         end
         pos = next;
      endfunction

      function void check_angles(angle_type roll, angle_type pitch, angle_type yaw);
         angle_triplet_type want;
         if (pending.size() == 0) begin
            $display("%0t unexpected result: roll %0d pitch %0d yaw %0d",
                     $time, roll, pitch, yaw);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (roll !== want.roll) begin
            $display("%0t roll mismatch: expected %0d actual %0d", $time, want.roll, roll);
            mismatches++;
         end
         if (pitch !== want.pitch) begin
            $display("%0t pitch mismatch: expected %0d actual %0d", $time, want.pitch, pitch);
            mismatches++;
         end
         if (yaw !== want.yaw) begin
            $display("%0t yaw mismatch: expected %0d actual %0d", $time, want.yaw, yaw);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [15:0] rsp_roll_angle;
   logic signed [15:0] rsp_pitch_angle;
   logic signed [15:0] rsp_yaw_angle;

   angle_frame_tracker tracker;
   stall_mode_type     stall_mode = StallFree;
   int                 stall_window = 0;
   int                 burst_left = 0;
   int                 bytes_sent = 0;
   int                 angle_packets = 0;
   int                 other_packets = 0;
   int                 broken_runs = 0;

   imu_angle_packet_parser_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_yaw_angle   (rsp_yaw_angle)
   );

   always #5 clock = ~clock;

   // receiver stalls in windows, each with its own pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            stall_window <= $urandom_range(16, 96);
         end else begin
            stall_window <= stall_window - 1;
         end
         case (stall_mode)
            StallFree:   rsp_stall <= 1'b0;
            StallLight:  rsp_stall <= ($urandom_range(0, 3) == 0);
            StallHeavy:  rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= (stall_window % 7) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_angles(rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle);
         end
      end
   end

   // sender works in bursts with random gaps in between
   task automatic send_byte(logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_rx_byte <= 8'($urandom);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0001;
         4:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // sends the first count bytes of a packet; filler bytes are random
   task automatic send_packet(logic [7:0] kind, logic [15:0] roll, logic [15:0] pitch,
                              logic [15:0] yaw, int count);
      logic [7:0] pkt [PacketLength];
      for (int i = 0; i < PacketLength; i++) begin
         pkt[i] = 8'($urandom);
      end
      pkt[0] = HeaderByte;
      pkt[1] = HeaderByte;
      pkt[2] = kind;
      {pkt[AngleBase + 1], pkt[AngleBase]}     = roll;
      {pkt[AngleBase + 3], pkt[AngleBase + 2]} = pitch;
      {pkt[AngleBase + 5], pkt[AngleBase + 4]} = yaw;
      for (int i = 0; i < count; i++) begin
         send_byte(pkt[i]);
      end
   endtask

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [7:0] kind;
      int         pick;
      tracker = new();
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: extreme angles, bad first byte, bad second byte, other type
      send_packet(TypeAngle, 16'h7FFF, 16'h8000, 16'hFFFF, PacketLength);
      angle_packets++;
      send_byte(8'h00);
      send_byte(HeaderByte);
      send_byte(HeaderByte);
      send_byte(8'hAA);
      send_packet(8'h02, 16'h0001, 16'h0000, 16'hFF01, PacketLength);
      other_packets++;

      while (bytes_sent < RandomBytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_packet(TypeAngle, pick_raw(), pick_raw(), pick_raw(), PacketLength);
            angle_packets++;
         end else if (pick < 80) begin
            kind = 8'($urandom);
            if (kind == TypeAngle) kind = HeaderByte;
            send_packet(kind, pick_raw(), pick_raw(), pick_raw(), PacketLength);
            other_packets++;
         end else if (pick < 88) begin
            send_packet(TypeAngle, pick_raw(), pick_raw(), pick_raw(),
                        $urandom_range(1, PacketLength - 1));
            broken_runs++;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_byte(($urandom_range(0, 2) == 0) ? HeaderByte : 8'($urandom));
            end
            broken_runs++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d bytes: %0d angle packets, %0d other-type packets, %0d broken runs",
               bytes_sent, angle_packets, other_packets, broken_runs);
      $display("checked %0d angle results, %0d mismatches", tracker.checked,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
